FILE: design/brainfuck_interpreter_core_assert.svh
// Assertion macros for the interpreter core.
// Used by brainfuck_interpreter_core.sv; needs clk and arst_n in scope.
`ifndef BRAINFUCK_INTERPRETER_CORE_ASSERT_SVH
`define BRAINFUCK_INTERPRETER_CORE_ASSERT_SVH

// Condition must hold at every edge outside reset.
`define BIC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent must hold at the same edge as the antecedent.
`define BIC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold at the edge after the antecedent.
`define BIC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/bic_pkg.sv
// Package for the interpreter core: command and response types, characters,
// status and phase codes, default sizes. No dependencies.
package bic_pkg;

	localparam int unsigned TAPE_CELLS_DEF = 1024;
	localparam int unsigned PROG_DEPTH_DEF = 1024;

	// Program characters
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_RIGHT   = 8'h3E;
	localparam logic [7:0] CH_LEFT    = 8'h3C;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_OPEN    = 8'h5B;
	localparam logic [7:0] CH_CLOSE   = 8'h5D;

	// Actions
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_EXEC = 1'b1;

	// Status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_TOO_LONG   = 2'd1;
	localparam logic [1:0] ST_UNMATCHED  = 2'd2;
	localparam logic [1:0] ST_NOT_LOADED = 2'd3;

	// Program phase
	localparam logic [1:0] PH_LOADING   = 2'd0;
	localparam logic [1:0] PH_READY     = 2'd1;
	localparam logic [1:0] PH_TOO_LONG  = 2'd2;
	localparam logic [1:0] PH_UNMATCHED = 2'd3;

	typedef struct packed {
		logic       action;
		logic [7:0] code_char;
		logic [7:0] in_byte;
	} cmd_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       done_res;
		logic [1:0] status;
	} rsp_t;

endpackage

FILE: design/brainfuck_interpreter_core.sv
// Interpreter core top level: program, bracket, jump and tape memories plus sequencer.
// Depends on bic_pkg and brainfuck_interpreter_core_assert.svh.
//
// Usage:
//   A command (cmd) transfers at a rising edge with start high and busy low.
//   action 0 loads one program character (newline ends the program);
//   action 1 executes one instruction of the loaded program.
//   Every command gives one response on rsp, marked by rsp_strobe for exactly
//   one cycle; the receiver cannot stall it.
// Sequencing:
//   Plain loads and non-running executes: the response is registered in the cycle after
//   the transfer edge, and the core can take the next command at once.
//   Executed instructions: tape and program read, then tape write in S_EXEC, busy high.
//   A closing bracket with a match: S_POP1 then S_POP2, busy high; the two jump table
//   writes share one memory port.
// Reset:
//   arst_n clears the control state, then the tape is zeroed one cell a cycle
//   with busy high, before the first command is taken.
//   The head and tape persist across programs until the next reset.
module brainfuck_interpreter_core #(
	parameter int unsigned TAPE_CELLS = bic_pkg::TAPE_CELLS_DEF,
	parameter int unsigned PROG_DEPTH = bic_pkg::PROG_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  bic_pkg::cmd_t cmd,
	output logic          rsp_strobe,
	output bic_pkg::rsp_t rsp
);
	import bic_pkg::*;
	`include "brainfuck_interpreter_core_assert.svh"

	localparam int unsigned AW = $clog2(PROG_DEPTH);
	localparam int unsigned LW = $clog2(PROG_DEPTH + 2);
	localparam int unsigned HW = $clog2(TAPE_CELLS);
	localparam logic [LW-1:0] PROG_MAX  = LW'(PROG_DEPTH);
	localparam logic [LW-1:0] PROG_OVF  = LW'(PROG_DEPTH + 1);
	localparam logic [HW-1:0] HEAD_LAST = HW'(TAPE_CELLS - 1);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_EXEC  = 3'd2;
	localparam logic [2:0] S_POP1  = 3'd3;
	localparam logic [2:0] S_POP2  = 3'd4;

	// Memories
	logic [7:0]    prog_mem  [PROG_DEPTH];
	logic [AW-1:0] jump_mem  [PROG_DEPTH];
	logic [AW-1:0] stack_mem [PROG_DEPTH];
	logic [7:0]    tape_mem  [TAPE_CELLS];

	// Control registers
	logic [2:0]    state_q;
	logic [1:0]    phase_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] level_q;
	logic [LW-1:0] pc_q;
	logic [HW-1:0] head_q;
	logic          bad_q;
	logic [HW-1:0] clr_addr_q;
	logic          rsp_strobe_q;
	rsp_t          rsp_q;

	// Payload registers
	logic [7:0]    in_byte_q;
	logic [LW-1:0] pos_q;
	logic [7:0]    prog_rd_q;
	logic [AW-1:0] jump_rd_q;
	logic [AW-1:0] stack_rd_q;
	logic [7:0]    tape_rd_q;

	// Transfer decode
	logic          accept;
	logic          is_load;
	logic          restart;
	logic [LW-1:0] eff_len;
	logic [LW-1:0] eff_level;
	logic          eff_bad;
	logic          is_nl;
	logic          room;
	logic          store;
	logic          push;
	logic          pop;
	logic          lone_close;
	logic          run_ok;
	logic          exec_go;
	logic [LW-1:0] lvl_m1;

	assign accept     = start && (state_q == S_IDLE);
	assign is_load    = accept && (cmd.action == ACT_LOAD);
	assign restart    = (phase_q != PH_LOADING);
	assign eff_len    = restart ? '0 : len_q;
	assign eff_level  = restart ? '0 : level_q;
	assign eff_bad    = restart ? 1'b0 : bad_q;
	assign is_nl      = (cmd.code_char == CH_NEWLINE);
	assign room       = (eff_len < PROG_MAX);
	assign store      = is_load && !is_nl && room;
	assign push       = store && (cmd.code_char == CH_OPEN);
	assign pop        = store && (cmd.code_char == CH_CLOSE) && (eff_level != '0);
	assign lone_close = store && (cmd.code_char == CH_CLOSE) && (eff_level == '0);
	assign lvl_m1     = eff_level - LW'(1);
	assign run_ok     = (phase_q == PH_READY) && (pc_q < len_q);
	assign exec_go    = accept && (cmd.action == ACT_EXEC) && run_ok;

	// Execute stage: decode the fetched instruction against the fetched cell
	logic          tape_we_x;
	logic [7:0]    cell_nx;
	logic [HW-1:0] head_nx;
	logic [LW-1:0] pc_nx;
	logic          emit;
	logic [LW-1:0] jump_nx;

	assign jump_nx = LW'(jump_rd_q) + LW'(1);

	always_comb begin
		tape_we_x = 1'b0;
		cell_nx   = tape_rd_q;
		head_nx   = head_q;
		pc_nx     = pc_q + LW'(1);
		emit      = 1'b0;
		unique case (prog_rd_q)
			CH_PLUS: begin
				tape_we_x = 1'b1;
				cell_nx   = tape_rd_q + 8'd1;
			end
			CH_MINUS: begin
				tape_we_x = 1'b1;
				cell_nx   = tape_rd_q - 8'd1;
			end
			CH_RIGHT: begin
				head_nx = (head_q == HEAD_LAST) ? '0 : head_q + HW'(1);
			end
			CH_LEFT: begin
				head_nx = (head_q == '0) ? HEAD_LAST : head_q - HW'(1);
			end
			CH_DOT: begin
				emit = 1'b1;
			end
			CH_COMMA: begin
				tape_we_x = 1'b1;
				cell_nx   = in_byte_q;
			end
			CH_OPEN: begin
				if (tape_rd_q == 8'd0) begin
					pc_nx = jump_nx;
				end
			end
			CH_CLOSE: begin
				if (tape_rd_q != 8'd0) begin
					pc_nx = jump_nx;
				end
			end
			default: begin
			end
		endcase
	end

	// Tape memory: clearing sweep after reset, else executed writes
	logic          tape_we;
	logic [HW-1:0] tape_wa;
	logic [7:0]    tape_wd;

	assign tape_we = (state_q == S_CLEAR) || ((state_q == S_EXEC) && tape_we_x);
	assign tape_wa = (state_q == S_CLEAR) ? clr_addr_q : head_q;
	assign tape_wd = (state_q == S_CLEAR) ? 8'd0 : cell_nx;

	always_ff @(posedge clk) begin
		if (tape_we) begin
			tape_mem[tape_wa] <= tape_wd;
		end
		if (exec_go) begin
			tape_rd_q <= tape_mem[head_q];
		end
	end

	// Program memory: written on load, read at pc
	always_ff @(posedge clk) begin
		if (store) begin
			prog_mem[eff_len[AW-1:0]] <= cmd.code_char;
		end
		if (exec_go) begin
			prog_rd_q <= prog_mem[pc_q[AW-1:0]];
		end
	end

	// Bracket stack: push on open, read the top on a matched close
	always_ff @(posedge clk) begin
		if (push) begin
			stack_mem[eff_level[AW-1:0]] <= eff_len[AW-1:0];
		end
		if (pop) begin
			stack_rd_q <= stack_mem[lvl_m1[AW-1:0]];
		end
	end

	// Jump table: both ends of a matched pair, one per cycle
	logic          jump_we;
	logic [AW-1:0] jump_wa;
	logic [AW-1:0] jump_wd;

	assign jump_we = (state_q == S_POP1) || (state_q == S_POP2);
	assign jump_wa = (state_q == S_POP1) ? stack_rd_q : pos_q[AW-1:0];
	assign jump_wd = (state_q == S_POP1) ? pos_q[AW-1:0] : stack_rd_q;

	always_ff @(posedge clk) begin
		if (jump_we) begin
			jump_mem[jump_wa] <= jump_wd;
		end
		if (exec_go) begin
			jump_rd_q <= jump_mem[pc_q[AW-1:0]];
		end
	end

	// Payload latches for multi-cycle commands
	always_ff @(posedge clk) begin
		if (accept) begin
			in_byte_q <= cmd.in_byte;
		end
		if (pop) begin
			pos_q <= eff_len;
		end
	end

	// Sequencer and program state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			phase_q      <= PH_LOADING;
			len_q        <= '0;
			level_q      <= '0;
			pc_q         <= '0;
			head_q       <= '0;
			bad_q        <= 1'b0;
			clr_addr_q   <= '0;
			rsp_strobe_q <= 1'b0;
			rsp_q        <= '0;
		end else begin
			rsp_strobe_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + HW'(1);
					if (clr_addr_q == HEAD_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						rsp_strobe_q    <= !exec_go;
						rsp_q.out_byte  <= 8'd0;
						rsp_q.out_valid <= 1'b0;
						rsp_q.done_res  <= 1'b0;
						rsp_q.status    <= ST_OK;
						if (is_load) begin
							len_q   <= eff_len;
							level_q <= eff_level;
							bad_q   <= eff_bad;
							if (restart) begin
								pc_q    <= '0;
								phase_q <= PH_LOADING;
							end
							if (is_nl) begin
								pc_q <= '0;
								priority if (eff_len > PROG_MAX) begin
									phase_q      <= PH_TOO_LONG;
									rsp_q.status <= ST_TOO_LONG;
								end else if (eff_bad || (eff_level != '0)) begin
									phase_q      <= PH_UNMATCHED;
									rsp_q.status <= ST_UNMATCHED;
								end else begin
									phase_q <= PH_READY;
								end
							end else if (!room) begin
								len_q <= PROG_OVF;
							end else begin
								len_q <= eff_len + LW'(1);
								if (push) begin
									level_q <= eff_level + LW'(1);
								end
								if (pop) begin
									level_q <= lvl_m1;
									state_q <= S_POP1;
								end
								if (lone_close) begin
									bad_q <= 1'b1;
								end
							end
						end else if (exec_go) begin
							state_q <= S_EXEC;
						end else begin
							unique case (phase_q)
								PH_LOADING:   rsp_q.status <= ST_NOT_LOADED;
								PH_TOO_LONG:  rsp_q.status <= ST_TOO_LONG;
								PH_UNMATCHED: rsp_q.status <= ST_UNMATCHED;
								default:      rsp_q.done_res <= 1'b1;
							endcase
						end
					end
				end
				S_EXEC: begin
					pc_q            <= pc_nx;
					head_q          <= head_nx;
					rsp_strobe_q    <= 1'b1;
					rsp_q.out_byte  <= emit ? tape_rd_q : 8'd0;
					rsp_q.out_valid <= emit;
					rsp_q.done_res  <= (pc_nx >= len_q);
					rsp_q.status    <= ST_OK;
					state_q         <= S_IDLE;
				end
				S_POP1: begin
					state_q <= S_POP2;
				end
				S_POP2: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign rsp_strobe = rsp_strobe_q;
	assign rsp        = rsp_q;

	// Checks
	`BIC_ASSERT_NEXT(a_rsp_follows_transfer, accept && !exec_go, rsp_strobe, "missing response")
	`BIC_ASSERT_NEXT(a_exec_responds, state_q == S_EXEC, rsp_strobe && !busy, "exec response lost")
	`BIC_ASSERT_ALWAYS(a_level_bounded, level_q <= len_q, "stack level above program length")
	`BIC_ASSERT_SAME(a_exec_in_range, state_q == S_EXEC, run_ok, "exec out of program")
	`BIC_ASSERT_SAME(a_emit_ok, rsp_strobe && rsp.out_valid, rsp.status == ST_OK, "emit with error")

endmodule
